>>> rtl/kswe_pkg.sv
package kswe_pkg;

    localparam int NIB_W     = 4;
    localparam int TILE_W    = 64;
    localparam int NUM_CELLS = TILE_W / NIB_W;
    localparam int MAX_BASES = 16;
    localparam int LEN_W     = 5;
    localparam int POS_W     = 32;

    typedef logic [NIB_W-1:0]  nib_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [TILE_W-1:0] tile_t;
    typedef logic [POS_W-1:0]  pos_t;

    localparam len_t MER_LEN_RESET = len_t'(13);

    // Per-cycle control shared by every cell of the window row.
    typedef struct packed {
        logic load;   // take a fresh window nibble and tile nibble
        logic shift;  // move one base toward base 0
    } cell_ctrl_t;

    // A length of zero acts as one base; anything above the row acts as full.
    function automatic len_t eff_length(input len_t raw);
        len_t n;
        n = raw;
        if (n == len_t'(0)) begin
            n = len_t'(1);
        end
        if (n > len_t'(MAX_BASES)) begin
            n = len_t'(MAX_BASES);
        end
        return n;
    endfunction

endpackage

>>> rtl/kswe_cell.sv
module kswe_cell (
    input  logic                clk,
    input  kswe_pkg::cell_ctrl_t ctrl,
    input  logic                is_top,
    input  kswe_pkg::nib_t      load_win,
    input  kswe_pkg::nib_t      load_tile,
    input  kswe_pkg::nib_t      up_win,
    input  kswe_pkg::nib_t      up_tile,
    input  kswe_pkg::nib_t      insert_nib,
    output kswe_pkg::nib_t      win_nib,
    output kswe_pkg::nib_t      tile_nib
);
    import kswe_pkg::*;

    nib_t win_reg;
    nib_t win_next;
    nib_t tile_reg;
    nib_t tile_next;

    // On a shift, the top base of the window takes the next nibble of the new
    // tile, ORed with whatever shifts down from above it.
    always_comb
    begin
        win_next  = win_reg;
        tile_next = tile_reg;
        if (ctrl.load) begin
            win_next  = load_win;
            tile_next = load_tile;
        end
        else if (ctrl.shift) begin
            win_next  = up_win | (is_top ? insert_nib : nib_t'(0));
            tile_next = up_tile;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        tile_reg <= tile_next;
    end

    assign win_nib  = win_reg;
    assign tile_nib = tile_reg;

endmodule

>>> rtl/kmer_sliding_window_expander.sv
// Sliding window expander for tiles of packed 4-bit bases. Each input beat
// carries one tile; once a previous tile is held, the next tile makes the
// block send mer_length window beats, one per cycle while the consumer is
// ready, starting with the held tile as it is and shifting one base per
// beat while the new tile's bases enter at the top base. A tile marked
// end_of_stream is also sent unchanged as one more beat, after which the
// position clears; the held tile is marked invalid when that tile is taken.
// The last beat caused by an input carries last_of_run. The row of sixteen
// nibble cells shifts once per result; the next tile is taken in the cycle
// that its predecessor's final result enters the output register, so with a
// ready consumer the row never stalls. The output register decouples the
// result side. mer_length is written through the cfg port while the block
// is idle; the block itself does not enforce this, the user must. Zero acts
// as one and values above sixteen act as sixteen.
module kmer_sliding_window_expander (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  kswe_pkg::len_t       cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  kswe_pkg::tile_t      tile_word,
    input  logic                 end_of_stream,
    output logic                 out_valid,
    input  logic                 out_ready,
    output kswe_pkg::tile_t      window_word,
    output kswe_pkg::pos_t       start_position,
    output logic                 last_of_run
);
    import kswe_pkg::*;

    len_t  mer_len_reg;
    tile_t held_tile_reg;
    logic  held_valid_reg;
    pos_t  pos_reg;
    pos_t  pos_next;
    len_t  win_left_reg;
    len_t  win_left_next;
    logic  eos_left_reg;
    logic  eos_left_next;

    logic  out_valid_reg;
    tile_t out_word_reg;
    pos_t  out_pos_reg;
    logic  out_last_reg;

    len_t  n_eff;
    len_t  top_idx;
    logic  accept;
    logic  advance;
    logic  active;
    logic  emit;
    logic  emit_win;
    logic  emit_last;

    tile_t      win_flat;
    cell_ctrl_t ctrl;

    nib_t win_nibs  [NUM_CELLS+1];
    nib_t tile_nibs [NUM_CELLS+1];

    assign n_eff   = eff_length(mer_len_reg);
    assign top_idx = n_eff - len_t'(1);

    // The engine has results pending while windows or the closing tile remain.
    assign active    = (win_left_reg != len_t'(0)) || eos_left_reg;
    assign advance   = !out_valid_reg || out_ready;
    assign emit      = active && advance;
    assign emit_win  = win_left_reg != len_t'(0);
    assign emit_last = emit_win ? ((win_left_reg == len_t'(1)) && !eos_left_reg) : 1'b1;

    // A new tile enters when the engine is idle or is sending its final beat.
    assign in_ready  = !active || (emit && emit_last);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign ctrl.load  = accept;
    assign ctrl.shift = emit && emit_win;

    // Row of cells: cell i takes from cell i+1; above the top cell zeros enter.
    assign win_nibs[NUM_CELLS]  = nib_t'(0);
    assign tile_nibs[NUM_CELLS] = nib_t'(0);

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        kswe_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .is_top     (top_idx == len_t'(i)),
            .load_win   (held_tile_reg[i*NIB_W +: NIB_W]),
            .load_tile  (tile_word[i*NIB_W +: NIB_W]),
            .up_win     (win_nibs[i+1]),
            .up_tile    (tile_nibs[i+1]),
            .insert_nib (tile_nibs[0]),
            .win_nib    (win_nibs[i]),
            .tile_nib   (tile_nibs[i])
        );
        assign win_flat[i*NIB_W +: NIB_W] = win_nibs[i];
    end

    always_comb
    begin
        win_left_next = win_left_reg;
        eos_left_next = eos_left_reg;
        pos_next      = pos_reg;
        if (emit)
        begin
            if (emit_win)
            begin
                win_left_next = win_left_reg - len_t'(1);
                pos_next      = pos_reg + pos_t'(1);
            end
            else
            begin
                eos_left_next = 1'b0;
                pos_next      = pos_t'(0);
            end
        end
        if (accept)
        begin
            win_left_next = held_valid_reg ? n_eff : len_t'(0);
            eos_left_next = end_of_stream;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mer_len_reg    <= MER_LEN_RESET;
            held_valid_reg <= 1'b0;
            pos_reg        <= pos_t'(0);
            win_left_reg   <= len_t'(0);
            eos_left_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mer_len_reg <= cfg_data;
            end
            if (accept)
            begin
                held_valid_reg <= !end_of_stream;
            end
            pos_reg      <= pos_next;
            win_left_reg <= win_left_next;
            eos_left_reg <= eos_left_next;
            if (advance)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    // The held tile is kept even on an end of stream: the closing beat reads
    // it, and held_valid gates every later use.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_tile_reg <= tile_word;
        end
        if (emit)
        begin
            out_word_reg <= emit_win ? win_flat : held_tile_reg;
            out_pos_reg  <= pos_reg;
            out_last_reg <= emit_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign window_word    = out_word_reg;
    assign start_position = out_pos_reg;
    assign last_of_run    = out_last_reg;

endmodule
